/* rtl/core/gar_pkg.sv */
package gar_pkg;

  localparam int MaxRefineDefault = 32;
  localparam int CoordWidth       = 32;
  localparam int SatWidth         = (CoordWidth < 32) ? CoordWidth : 32;

  typedef enum logic [1:0] {
    ActOld   = 2'd0,
    ActLoad  = 2'd1,
    ActClear = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    UpcIdle  = 3'd0,
    UpcPush  = 3'd1,
    UpcScan  = 3'd2,
    UpcEnd   = 3'd3,
    UpcClose = 3'd4
  } upc_e;

  typedef enum logic [2:0] {
    OpFetch   = 3'd0,
    OpPushOld = 3'd1,
    OpScan    = 3'd2,
    OpNop     = 3'd3,
    OpClose   = 3'd4
  } uop_e;

  typedef enum logic [1:0] {
    CondAlways  = 2'd0,
    CondOldCell = 2'd1,
    CondHit     = 2'd2,
    CondLast    = 2'd3
  } ucond_e;

  typedef struct packed {
    uop_e   op;
    ucond_e cond;
    upc_e   tgt_true;
    upc_e   tgt_false;
  } ucode_t;

  function automatic ucode_t ucode_rom(upc_e upc);
    ucode_t w;
    unique case (upc)
      UpcIdle:  w = '{op: OpFetch,   cond: CondOldCell, tgt_true: UpcPush, tgt_false: UpcIdle};
      UpcPush:  w = '{op: OpPushOld, cond: CondAlways,  tgt_true: UpcScan, tgt_false: UpcScan};
      UpcScan:  w = '{op: OpScan,    cond: CondHit,     tgt_true: UpcScan, tgt_false: UpcEnd};
      UpcEnd:   w = '{op: OpNop,     cond: CondLast,    tgt_true: UpcClose, tgt_false: UpcIdle};
      UpcClose: w = '{op: OpClose,   cond: CondAlways,  tgt_true: UpcIdle, tgt_false: UpcIdle};
      default:  w = '{op: OpNop,     cond: CondAlways,  tgt_true: UpcIdle, tgt_false: UpcIdle};
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat_width(logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = (34'sd1 <<< (SatWidth - 1)) - 34'sd1;
    lo = -hi - 34'sd1;
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

endpackage

/* rtl/core/grid_axis_refinement_merge.sv */
// Grid axis refinement merge.
// Input channel (in_valid_i / in_stall_o) carries one item per handshake:
// action 1 loads a sorted refinement coordinate into the store, action 2
// clears the store and the scan position, action 0 delivers one old cell
// (start coordinate, size, last flag). Action 3 is ignored.
// Output channel (out_valid_o / out_stall_i) carries one refined cell width
// per item; end_of_axis_o marks the closing width, size_error_o flags a
// closing width that is zero or negative.
// Load, clear and ignored items are taken in the idle step. An old cell runs
// the push, scan and end steps, plus the close step on the last cell of the
// axis; the scan reads one store entry per cycle while the output does not
// stall. A microcode step counter walks a five-step program.
// An old cell's first width is emitted from the push step into the output
// register, unless that cell opens the axis.
// Reset empties the store count, scan position and pending boundary and
// drops any waiting output item. While the receiver stalls, the output
// register holds its item and the sequencer waits at the step that would
// emit the next width; in_stall_o stays high until the old cell is done.
module grid_axis_refinement_merge
  import gar_pkg::*;
#(
  parameter int MAX_REFINE = MaxRefineDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] coordinate_i,
  input  logic [30:0]        cell_size_i,
  input  logic               last_cell_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_width_o,
  output logic               end_of_axis_o,
  output logic               size_error_o
);

  localparam int CntW = $clog2(MAX_REFINE + 1);
  localparam int IdxW = (MAX_REFINE > 1) ? $clog2(MAX_REFINE) : 1;

  upc_e                upc_q, upc_d;
  ucode_t              uw;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     pos_q, pos_d;
  logic signed [31:0]  pend_q, pend_d;
  logic                have_q, have_d;
  logic signed [31:0]  coord_q;
  logic [30:0]         size_q;
  logic                last_q;
  logic signed [32:0]  limit_q;
  logic signed [31:0]  rd_q;
  logic signed [31:0]  store_mem [MAX_REFINE];

  logic                accept, ld_old, cond, hold, hit, out_free;
  logic                wr_en;
  logic [IdxW-1:0]     wr_idx, rd_idx;
  logic                emit, emit_end, emit_err;
  logic signed [31:0]  emit_w;
  logic signed [33:0]  final_w;

  logic                out_valid_q;
  logic signed [31:0]  width_q;
  logic                end_q, err_q;

  assign in_stall_o    = (upc_q != UpcIdle);
  assign accept        = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign uw            = ucode_rom(upc_q);
  assign hit           = (pos_q < count_q) && ($signed({rd_q[31], rd_q}) < limit_q);
  assign wr_idx        = count_q[IdxW-1:0];
  assign rd_idx        = (pos_d < CntW'(MAX_REFINE)) ? pos_d[IdxW-1:0] : '0;
  assign final_w       = $signed({3'b000, size_q}) + $signed({{2{coord_q[31]}}, coord_q})
                         - $signed({{2{pend_q[31]}}, pend_q});
  assign out_valid_o   = out_valid_q;
  assign new_width_o   = width_q;
  assign end_of_axis_o = end_q;
  assign size_error_o  = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UpcIdle;
      count_q     <= '0;
      pos_q       <= '0;
      pend_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q   <= upc_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      have_q  <= have_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_old) begin
      coord_q <= coordinate_i;
      size_q  <= cell_size_i;
      last_q  <= last_cell_i;
      limit_q <= $signed({coordinate_i[31], coordinate_i}) + $signed({2'b00, cell_size_i});
    end
    if (emit) begin
      width_q <= emit_w;
      end_q   <= emit_end;
      err_q   <= emit_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_idx] <= coordinate_i;
    end
    if (wr_en && (wr_idx == rd_idx)) begin
      rd_q <= coordinate_i;
    end else begin
      rd_q <= store_mem[rd_idx];
    end
  end

  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    pend_d   = pend_q;
    have_d   = have_q;
    ld_old   = 1'b0;
    wr_en    = 1'b0;
    hold     = 1'b0;
    emit     = 1'b0;
    emit_w   = '0;
    emit_end = 1'b0;
    emit_err = 1'b0;

    unique case (uw.cond)
      CondAlways:  cond = 1'b1;
      CondOldCell: cond = accept && (action_i == ActOld);
      CondHit:     cond = hit;
      CondLast:    cond = last_q;
      default:     cond = 1'b0;
    endcase

    unique case (uw.op)
      OpFetch: begin
        if (accept) begin
          unique case (action_i)
            ActOld:   ld_old = 1'b1;
            ActLoad: begin
              if (count_q < CntW'(MAX_REFINE)) begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            ActClear: begin
              count_d = '0;
              pos_d   = '0;
              pend_d  = '0;
              have_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      OpPushOld: begin
        if (have_q && !out_free) begin
          hold = 1'b1;
        end else begin
          emit   = have_q;
          emit_w = sat_width($signed({{2{coord_q[31]}}, coord_q})
                             - $signed({{2{pend_q[31]}}, pend_q}));
          pend_d = coord_q;
          have_d = 1'b1;
          if ((pos_q < count_q) && (rd_q == coord_q)) begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      OpScan: begin
        if (hit) begin
          if (have_q && !out_free) begin
            hold = 1'b1;
          end else begin
            emit   = have_q;
            emit_w = sat_width($signed({{2{rd_q[31]}}, rd_q})
                               - $signed({{2{pend_q[31]}}, pend_q}));
            pend_d = rd_q;
            have_d = 1'b1;
            pos_d  = pos_q + 1'b1;
          end
        end
      end
      OpClose: begin
        if (!out_free) begin
          hold = 1'b1;
        end else begin
          emit     = 1'b1;
          emit_w   = sat_width(final_w);
          emit_end = 1'b1;
          emit_err = (final_w <= 34'sd0);
          have_d   = 1'b0;
          pend_d   = '0;
          pos_d    = '0;
        end
      end
      OpNop: ;
      default: ;
    endcase

    if (hold) begin
      upc_d = upc_q;
    end else if (cond) begin
      upc_d = uw.tgt_true;
    end else begin
      upc_d = uw.tgt_false;
    end
  end

endmodule

/* rtl/core/gar_checker.sv */
module gar_checker
  import gar_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         action_i,
  input logic signed [31:0] coordinate_i,
  input logic [30:0]        cell_size_i,
  input logic               last_cell_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] new_width_o,
  input logic               end_of_axis_o,
  input logic               size_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_width_o)
      && $stable(end_of_axis_o) && $stable(size_error_o))
    else $error("stalled output item changed");

  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_axis_o |-> !size_error_o)
    else $error("size error on a width that does not close the axis");

  a_err_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_axis_o |-> size_error_o == (new_width_o <= 32'sd0))
    else $error("size error does not match the closing width");

  a_short_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i != ActOld) |=> !in_stall_o)
    else $error("load or clear item kept the input stalled");

  a_old_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ActOld) |=> in_stall_o)
    else $error("old cell item did not stall the input");

endmodule

bind grid_axis_refinement_merge gar_checker u_gar_checker (.*);

/* tb/sv/grid_axis_refinement_merge_tb.sv */
`timescale 1ns / 1ps

module grid_axis_refinement_merge_tb;
  import gar_pkg::*;

  localparam int MaxRefine = MaxRefineDefault;
  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic [31:0] CoordMin = 32'h8000_0000;
  localparam logic [31:0] CoordMax = 32'h7fff_ffff;
  localparam logic [30:0] SizeMax = 31'h7fff_ffff;
  localparam longint WidthHi = 64'sd2147483647;
  localparam longint WidthLo = -64'sd2147483648;
  localparam int RxHoldCycles = 300;
  localparam int StallLimit = 3000;
  localparam int PostDrain = 20;
  localparam int MaxShown = 10;

  typedef struct packed {
    logic [31:0] width;
    logic        axis_end;
    logic        neg_err;
  } width_rec_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         action_i;
  logic signed [31:0] coordinate_i;
  logic [30:0]        cell_size_i;
  logic               last_cell_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] new_width_o;
  logic               end_of_axis_o;
  logic               size_error_o;

  width_rec_t  width_q[$];
  longint      refine_mem[MaxRefine];
  int unsigned refine_cnt;
  int unsigned refine_idx;
  longint      open_edge;
  bit          edge_open;

  int unsigned items_sent;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          idle_on = 1'b1;
  bit          rx_hold_pending = 1'b0;

  grid_axis_refinement_merge u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .coordinate_i (coordinate_i),
    .cell_size_i  (cell_size_i),
    .last_cell_i  (last_cell_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .new_width_o  (new_width_o),
    .end_of_axis_o(end_of_axis_o),
    .size_error_o (size_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_width(longint w, bit fin, bit err);
    width_rec_t r;
    if (w > WidthHi) begin
      w = WidthHi;
    end else if (w < WidthLo) begin
      w = WidthLo;
    end
    r.width = w[31:0];
    r.axis_end = fin;
    r.neg_err = err;
    width_q = {width_q, r};
  endfunction

  function automatic void push_edge(longint b);
    if (edge_open) begin
      push_width(b - open_edge, 1'b0, 1'b0);
    end
    open_edge = b;
    edge_open = 1'b1;
  endfunction

  function automatic void predict_widths(logic [1:0] act, logic [31:0] crd, logic [30:0] sz,
                                         logic lst);
    longint c;
    longint s;
    longint lim;
    longint w;
    c = longint'($signed(crd));
    s = longint'(sz);
    if (act == ActLoad) begin
      if (refine_cnt < MaxRefine) begin
        refine_mem[refine_cnt] = c;
        refine_cnt++;
      end
    end else if (act == ActClear) begin
      refine_cnt = 0;
      refine_idx = 0;
      open_edge = 0;
      edge_open = 1'b0;
    end else if (act == ActOld) begin
      push_edge(c);
      if (refine_idx < refine_cnt && refine_mem[refine_idx] == c) begin
        refine_idx++;
      end
      lim = c + s;
      while (refine_idx < refine_cnt && refine_mem[refine_idx] < lim) begin
        push_edge(refine_mem[refine_idx]);
        refine_idx++;
      end
      if (lst) begin
        w = s + c - open_edge;
        push_width(w, 1'b1, w <= 0);
        edge_open = 1'b0;
        open_edge = 0;
        refine_idx = 0;
      end
    end
  endfunction

  task automatic send_item(logic [1:0] act, logic [31:0] crd, logic [30:0] sz, logic lst);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    coordinate_i <= crd;
    cell_size_i <= sz;
    last_cell_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_widths(act, crd, sz, lst);
    if (act != ActUnused) begin
      items_sent++;
    end
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), $urandom, 31'($urandom), 1'($urandom));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (width_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_axis();
    longint cell_start[6];
    longint cell_len[6];
    longint marks[$];
    longint lo;
    longint hi;
    longint pos;
    int     n_cell;
    int     n_ref;
    int     span;
    int     k;
    case ($urandom_range(0, 2))
      0: span = 16;
      1: span = 4096;
      default: span = 1 << 20;
    endcase
    n_cell = $urandom_range(1, 6);
    pos = longint'($urandom_range(0, 32'h4000_0000)) - 64'sd536870912;
    for (k = 0; k < n_cell; k++) begin
      cell_start[k] = pos;
      cell_len[k] = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(0, span));
      pos += cell_len[k];
    end
    lo = cell_start[0] - span;
    hi = pos + span;
    n_ref = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 8);
    for (k = 0; k < n_ref; k++) begin
      if ($urandom_range(0, 2) == 0) begin
        marks = {marks, cell_start[$urandom_range(0, n_cell - 1)]};
      end else begin
        marks = {marks, lo + longint'($urandom_range(0, 32'(hi - lo)))};
      end
    end
    marks.sort();
    if ($urandom_range(0, 11) == 0) begin
      send_noise();
    end
    if ($urandom_range(0, 4) != 0) begin
      send_item(ActClear, $urandom, 31'($urandom), 1'($urandom));
    end
    for (k = 0; k < n_ref; k++) begin
      send_item(ActLoad, marks[k][31:0], 31'($urandom), 1'($urandom));
    end
    for (k = 0; k < n_cell; k++) begin
      if (k == n_cell - 1 && $urandom_range(0, 11) == 0) begin
        send_noise();
      end
      send_item(ActOld, cell_start[k][31:0], cell_len[k][30:0], k == n_cell - 1);
    end
  endtask

  task automatic run_axes_until(int unsigned n);
    int unsigned goal;
    goal = items_sent + n;
    while (items_sent < goal) run_axis();
  endtask

  task automatic test_first_axis();
    send_item(ActClear, '0, '0, 1'b0);
    send_item(ActLoad, 32'd128, '0, 1'b0);
    send_item(ActLoad, 32'd256, '0, 1'b0);
    send_item(ActLoad, 32'd700, '0, 1'b0);
    send_item(ActOld, 32'd0, 31'd256, 1'b0);
    send_item(ActOld, 32'd256, 31'd256, 1'b0);
    send_item(ActOld, 32'd512, 31'd256, 1'b1);
  endtask

  task automatic test_extremes();
    send_item(ActClear, CoordMax, SizeMax, 1'b1);
    send_item(ActLoad, CoordMin, SizeMax, 1'b1);
    send_item(ActOld, CoordMax, SizeMax, 1'b1);
    send_item(ActOld, CoordMin, '0, 1'b1);
    send_item(ActOld, 32'hffff_ff00, 31'd1, 1'b1);
  endtask

  task automatic test_unused_action();
    send_item(ActUnused, '1, '1, 1'b1);
    send_item(ActUnused, '0, '0, 1'b0);
    send_item(ActOld, '0, SizeMax, 1'b1);
  endtask

  task automatic test_store_full();
    int k;
    send_item(ActClear, '0, '0, 1'b0);
    for (k = 0; k <= MaxRefine; k++) begin
      send_item(ActLoad, 32'((k + 1) * 16), '0, 1'b0);
    end
    send_item(ActOld, -32'sd16, 31'd16, 1'b0);
    send_item(ActOld, 32'd0, 31'd1024, 1'b1);
  endtask

  task automatic test_random_axes();
    run_axes_until(200);
  endtask

  task automatic test_receiver_hold();
    rx_hold_pending = 1'b1;
    run_axes_until(40);
  endtask

  task automatic test_sender_pause();
    run_axis();
    drain_results();
    run_axes_until(20);
  endtask

  task automatic test_quiet_finish();
    idle_on = 1'b0;
    run_axes_until(40);
  endtask

  initial begin : rx_side
    int   hold_len;
    logic hold_val;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (rx_hold_pending) begin
        rx_hold_pending = 1'b0;
        hold_val = 1'b1;
        hold_len = RxHoldCycles;
      end else if (!idle_on) begin
        hold_val = 1'b0;
        hold_len = 1;
      end else begin
        case ($urandom_range(0, 7))
          0, 1: begin
            hold_val = 1'b1;
            hold_len = $urandom_range(1, 8);
          end
          2: begin
            hold_val = 1'b0;
            hold_len = $urandom_range(20, 60);
          end
          default: begin
            hold_val = 1'b0;
            hold_len = $urandom_range(1, 6);
          end
        endcase
      end
      out_stall_i <= hold_val;
      repeat (hold_len) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : width_check
    width_rec_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (width_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) begin
          $display("[%0t] unexpected width %0d end %0b err %0b", $realtime,
                   new_width_o, end_of_axis_o, size_error_o);
        end
      end else begin
        r = width_q.pop_front();
        if (r.width !== new_width_o || r.axis_end !== end_of_axis_o ||
            r.neg_err !== size_error_o) begin
          mismatches++;
          if (mismatches <= MaxShown) begin
            $display("[%0t] width mismatch: exp %0d end %0b err %0b, got %0d end %0b err %0b",
                     $realtime, $signed(r.width), r.axis_end, r.neg_err,
                     new_width_o, end_of_axis_o, size_error_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    items_sent = 0;
    mismatches = 0;
    refine_cnt = 0;
    refine_idx = 0;
    open_edge = 0;
    edge_open = 1'b0;
    in_valid_i <= 1'b0;
    action_i <= ActClear;
    coordinate_i <= '0;
    cell_size_i <= '0;
    last_cell_i <= 1'b0;
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_axis();
    test_extremes();
    test_unused_action();
    test_store_full();
    test_random_axes();
    test_receiver_hold();
    test_sender_pause();
    test_quiet_finish();
    drain_results();
    repeat (PostDrain) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/gar_pkg.sv
rtl/core/grid_axis_refinement_merge.sv
rtl/core/gar_checker.sv
tb/sv/grid_axis_refinement_merge_tb.sv
